@@ rtl/tscu_pkg.sv @@
package tscu_pkg;

  localparam int FRAC_BITS     = 24;
  localparam int MAX_ORDER_DEF = 31;
  localparam int ORD_W         = 6;
  localparam int CFG_W         = 5;
  localparam int ANG_W         = 32;
  localparam int MAG_W         = 32;
  localparam int XW            = FRAC_BITS + 3;
  localparam int TW            = 32;
  localparam int PW            = TW + XW - FRAC_BITS;
  localparam int VW            = PW + 1;
  localparam int SW            = 40;
  localparam int RED_STEPS     = 5;
  localparam int CFG_RESET     = 15;

  localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;
  localparam logic [63:0] TWO_PI_FULL =
    (TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [MAG_W-1:0] TWO_PI = TWO_PI_FULL[MAG_W-1:0];

  typedef struct packed {
    logic             valid;
    logic             cosine;
    logic             neg;
    logic [ORD_W-1:0] order;
  } tscu_side_t;

  typedef struct packed {
    tscu_side_t             side;
    logic [XW-1:0]          x;
    logic [TW-1:0]          term;
    logic signed [SW-1:0]   sum;
    logic signed [SW-1:0]   err;
    logic                   minus;
  } tscu_lane_t;

endpackage

@@ rtl/tscu_in_if.sv @@
interface tscu_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] angle;
  modport source (output valid, mode, angle, input ready);
  modport sink (input valid, mode, angle, output ready);
endinterface

@@ rtl/tscu_out_if.sv @@
interface tscu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic signed [31:0] error_bound;
  modport source (output valid, value, error_bound, input ready);
  modport sink (input valid, value, error_bound, output ready);
endinterface

@@ rtl/tscu_cfg_if.sv @@
interface tscu_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/tscu_reduce_cell.sv @@
module tscu_reduce_cell #(
  parameter int unsigned K = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  tscu_pkg::tscu_side_t     side_in,
  input  logic [tscu_pkg::MAG_W-1:0] r_in,
  output tscu_pkg::tscu_side_t     side_out,
  output logic [tscu_pkg::MAG_W-1:0] r_out
);
  import tscu_pkg::*;

  localparam logic [MAG_W-1:0] SUB = TWO_PI << K;

  // One restoring step of the reduction by the rounded 2*pi constant.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
      r_out    <= (r_in >= SUB) ? (r_in - SUB) : r_in;
    end
  end

endmodule

@@ rtl/tscu_term_cell.sv @@
module tscu_term_cell #(
  parameter int unsigned N = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  tscu_pkg::tscu_lane_t lane_in,
  output tscu_pkg::tscu_lane_t lane_out
);
  import tscu_pkg::*;

  localparam int S = VW;
  localparam logic [S:0]       M      = (S+1)'((65'd1 << S) / N);
  localparam logic [17:0]      M_LO   = M[17:0];
  localparam logic [S-18:0]    M_HI   = M[S:18];
  localparam logic [VW-1:0]    HALF_N = VW'(N / 2);
  localparam logic [6:0]       N_C    = 7'(N);
  localparam logic [VW-1:0]    N_V    = VW'(N);
  localparam logic             N_ODD  = N_C[0];

  logic [TW+XW-1:0]   prod;
  logic [TW+XW-1:0]   prod_rnd;
  logic [VW-1:0]      v_a;
  tscu_lane_t         a_l, b_l, c_l, d_l;
  tscu_lane_t         d_next, out_next;
  logic [VW-1:0]      a_v, b_v, c_v;
  logic [VW+17:0]     pp_lo;
  logic [VW+S-18:0]   pp_hi;
  logic [VW+S:0]      full;
  logic [VW-1:0]      c_q;
  logic [VW+6:0]      qn;
  logic [VW-1:0]      rem;
  logic [VW-1:0]      q;
  logic               sum_upd, err_upd;
  logic [6:0]         ord7;

  assign prod     = lane_in.term * lane_in.x;
  assign prod_rnd = prod + (TW+XW)'(1 << (FRAC_BITS - 1));
  assign v_a      = {1'b0, prod_rnd[TW+XW-1:FRAC_BITS]} + HALF_N;

  // Stage A: rounded product; B: reciprocal partial products; C: quotient estimate; D: corrected term.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_l.side.valid <= 1'b0;
      b_l.side.valid <= 1'b0;
      c_l.side.valid <= 1'b0;
      d_l.side.valid <= 1'b0;
    end else if (en) begin
      a_l   <= lane_in;
      a_v   <= v_a;
      b_l   <= a_l;
      b_v   <= a_v;
      pp_lo <= a_v * M_LO;
      pp_hi <= a_v * M_HI;
      c_l   <= b_l;
      c_v   <= b_v;
      c_q   <= full[S +: VW];
      d_l   <= d_next;
    end
  end

  assign full = {pp_hi, 18'd0} + (VW+S+1)'(pp_lo);

  // The reciprocal quotient is at most one short; one compare fixes it.
  assign qn  = c_q * N_C;
  assign rem = c_v - qn[VW-1:0];
  assign q   = (rem >= N_V) ? (c_q + 1'b1) : c_q;

  always_comb begin
    d_next      = c_l;
    d_next.term = q[TW-1:0];
  end

  assign ord7    = 7'(d_l.side.order);
  assign sum_upd = (N_C <= ord7) && (d_l.side.cosine != N_ODD);
  assign err_upd = (d_l.side.cosine == N_ODD) && ((N_C - 7'd1) <= ord7) &&
                   (d_l.side.cosine || (N_C >= 7'd2));

  always_comb begin
    out_next = d_l;
    if (sum_upd) begin
      out_next.sum   = d_l.minus ? (d_l.sum - SW'(d_l.term)) : (d_l.sum + SW'(d_l.term));
      out_next.minus = ~d_l.minus;
    end
    if (err_upd) begin
      out_next.err = SW'(d_l.term);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.side.valid <= 1'b0;
    end else if (en) begin
      lane_out <= out_next;
    end
  end

endmodule

@@ rtl/tscu_out_buf.sv @@
module tscu_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic signed [31:0] push_value,
  input  logic signed [31:0] push_err,
  output logic               en,
  tscu_out_if.source         result
);
  import tscu_pkg::*;

  logic signed [31:0] val_mem [0:1];
  logic signed [31:0] err_mem [0:1];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         cnt;
  logic               pop, wr;

  assign pop          = result.valid && result.ready;
  assign en           = (cnt != 2'd2) || result.ready;
  assign wr           = push && en;
  assign result.valid = (cnt != 2'd0);
  assign result.value       = val_mem[rd_ptr];
  assign result.error_bound = err_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      val_mem[wr_ptr] <= push_value;
      err_mem[wr_ptr] <= push_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, wr} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !result.ready) |-> !wr)
    else $error("write into a full output buffer");
  a_reset_empty: assert property (@(posedge clk) rst |=> cnt == 2'd0)
    else $error("output buffer not empty after reset");

endmodule

@@ rtl/taylor_sine_cosine_unit_core.sv @@
// Taylor-series sine/cosine unit.
// sample carries mode (0 sine, 1 cosine) and a signed Q8.24 angle; result
// carries the series sum and the next-term error bound, both Q8.24 and
// saturated. Both channels transfer on valid and ready high at a clock edge.
// cfg writes the 5-bit series order; it is always ready and should only be
// written while no item is in flight.
// The angle passes five restoring reduction cells, then one term cell per
// power 1..MAX_ORDER+1, each five stages deep, then a two-entry output buffer.
// Throughput is one item per cycle unless stalled; the whole chain advances together.
// When the receiver stalls, the output buffer still takes one more result,
// after which the chain and sample.ready hold until a result transfers.
// Reset (rst, synchronous) empties the chain and buffer and sets the order
// to 15.
module taylor_sine_cosine_unit_core #(
  parameter int unsigned MAX_ORDER = tscu_pkg::MAX_ORDER_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tscu_in_if.sink    sample,
  tscu_out_if.source result,
  tscu_cfg_if.sink   cfg
);
  import tscu_pkg::*;

  localparam int NCELL = MAX_ORDER + 1;

  logic [CFG_W-1:0]   series_order;
  logic [ORD_W-1:0]   ord_clamp;
  logic               en;
  logic [MAG_W-1:0]   mag;
  tscu_side_t         side_in;
  tscu_side_t         red_side [0:RED_STEPS];
  logic [MAG_W-1:0]   red_r    [0:RED_STEPS];
  tscu_lane_t         lanes    [0:NCELL];
  logic signed [SW-1:0] fsum;
  logic signed [31:0] out_value, out_err;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > SW'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (v < -SW'(64'sh80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      series_order <= CFG_W'(CFG_RESET);
    end else if (cfg.valid) begin
      series_order <= cfg.data;
    end
  end

  assign ord_clamp = (ORD_W'(series_order) > ORD_W'(MAX_ORDER)) ?
                     ORD_W'(MAX_ORDER) : ORD_W'(series_order);

  assign sample.ready   = en;
  assign mag            = sample.angle[31] ? (MAG_W'(0) - MAG_W'(sample.angle))
                                           : MAG_W'(sample.angle);
  assign side_in.valid  = sample.valid;
  assign side_in.cosine = sample.mode;
  assign side_in.neg    = sample.angle[31];
  assign side_in.order  = ord_clamp;
  assign red_side[0]    = side_in;
  assign red_r[0]       = mag;

  for (genvar i = 0; i < RED_STEPS; i++) begin : g_red
    tscu_reduce_cell #(.K(RED_STEPS - 1 - i)) u_red (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .side_in  (red_side[i]),
      .r_in     (red_r[i]),
      .side_out (red_side[i+1]),
      .r_out    (red_r[i+1])
    );
  end

  // The cosine series starts from the power-zero term, 1.0, already summed.
  always_comb begin
    lanes[0].side  = red_side[RED_STEPS];
    lanes[0].x     = red_r[RED_STEPS][XW-1:0];
    lanes[0].term  = TW'(1) << FRAC_BITS;
    lanes[0].sum   = red_side[RED_STEPS].cosine ? (SW'(1) <<< FRAC_BITS) : SW'(0);
    lanes[0].err   = -(SW'(1) <<< FRAC_BITS);
    lanes[0].minus = red_side[RED_STEPS].cosine;
  end

  for (genvar n = 1; n <= NCELL; n++) begin : g_term
    tscu_term_cell #(.N(n)) u_term (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (lanes[n-1]),
      .lane_out (lanes[n])
    );
  end

  assign fsum      = (lanes[NCELL].side.neg && !lanes[NCELL].side.cosine) ?
                     -lanes[NCELL].sum : lanes[NCELL].sum;
  assign out_value = sat32(fsum);
  assign out_err   = sat32(lanes[NCELL].err);

  tscu_out_buf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (lanes[NCELL].side.valid),
    .push_value (out_value),
    .push_err   (out_err),
    .en         (en),
    .result     (result)
  );

endmodule
